[hw/rtl/fzs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzs_pkg
// Shared types, constants and a helper function of the fuzzy subsequence
// scorer: item and configuration structs, score arithmetic, register map.
// ----------------------------------------------------------------------------
package fzs_pkg;

    // Sizes.
    localparam int NEEDLE_MAX  = 32;
    localparam int NPOS_W      = $clog2(NEEDLE_MAX + 1);
    localparam int NIDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int ENTRY_MAX   = 1024;
    localparam int ENTRY_W     = $clog2(ENTRY_MAX);
    localparam int SCORE_W     = 10;
    localparam int LEN_W       = 7;
    localparam int GAP_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam logic [2:0] REG_NLEN  = 3'd0;
    localparam logic [2:0] REG_WORD0 = 3'd1;
    localparam logic [2:0] REG_WORD1 = 3'd2;
    localparam logic [2:0] REG_WORD2 = 3'd3;
    localparam logic [2:0] REG_WORD3 = 3'd4;

    // Scoring constants.
    localparam int SCORE_MAX    = 511;
    localparam int SCORE_MIN    = -512;
    localparam int ADD_WORD     = 10;
    localparam int ADD_RUN      = 8;
    localparam int ADD_OTHER    = 1;
    localparam int GAP_CAP      = 4;
    localparam int LABEL_BONUS  = 40;
    localparam int LEN_BASE     = 8;
    localparam int LEN_CAP      = 64;
    localparam int DISABLED_PEN = 12;

    // Characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic signed [SCORE_W-1:0] t_score;

    // One classified character transaction.
    typedef struct packed {
        logic [7:0] ch_fold;
        logic       sep;
        logic       has_char;
        logic       in_group;
        logic       string_end;
        logic       enabled;
        logic       new_list;
    } t_item;

    // Needle configuration seen by the back end.
    typedef struct packed {
        logic [NPOS_W-1:0]       nlen;
        logic [8*NEEDLE_MAX-1:0] needle;
    } t_cfg;

    // Queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Saturating add over the score range.
    function automatic t_score sat_add(input t_score a, input t_score b);
        logic signed [SCORE_W:0] s;
        t_score                  r;
        s = (SCORE_W + 1)'(a) + (SCORE_W + 1)'(b);
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            r = s[SCORE_W] ? t_score'(SCORE_MIN) : t_score'(SCORE_MAX);
        end else begin
            r = s[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/fzs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzs_front
// Input classifier: folds uppercase ASCII, flags word separators and packs
// the transaction for the queue.
// ----------------------------------------------------------------------------
module fzs_front (
    input  logic            i_valid,
    input  logic [7:0]      i_text_char,
    input  logic            i_has_char,
    input  logic            i_in_group,
    input  logic            i_string_end,
    input  logic            i_entry_enabled,
    input  logic            i_new_list,
    input  fzs_pkg::t_qstat i_qstat,
    output logic            o_ready,
    output logic            o_push,
    output fzs_pkg::t_item  o_item
);

    logic is_upper;

    // Case folding and separator detection on the raw byte.
    assign is_upper = (i_text_char >= fzs_pkg::CH_UP_A) && (i_text_char <= fzs_pkg::CH_UP_Z);

    always_comb begin
        o_item.ch_fold    = is_upper ? (i_text_char + fzs_pkg::CASE_OFS) : i_text_char;
        o_item.sep        = (i_text_char == fzs_pkg::CH_SPACE) ||
                            (i_text_char == fzs_pkg::CH_UNDER) ||
                            (i_text_char == fzs_pkg::CH_DOT)   ||
                            (i_text_char == fzs_pkg::CH_DASH)  ||
                            (i_text_char == fzs_pkg::CH_SLASH);
        o_item.has_char   = i_has_char;
        o_item.in_group   = i_in_group;
        o_item.string_end = i_string_end;
        o_item.enabled    = i_entry_enabled;
        o_item.new_list   = i_new_list;
    end

    // Accept whenever the queue has room.
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

endmodule

[hw/rtl/fzs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzs_queue
// Short first-in first-out queue of classified transactions between the
// front end and the back end.
// ----------------------------------------------------------------------------
module fzs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fzs_pkg::t_item  i_item,
    input  logic            i_pop,
    output fzs_pkg::t_item  o_head,
    output fzs_pkg::t_qstat o_stat
);

    fzs_pkg::t_item                   r_mem [fzs_pkg::QUEUE_DEPTH];
    logic [fzs_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [fzs_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [fzs_pkg::QCNT_W-1:0]       r_count, n_count;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == fzs_pkg::QCNT_W'(fzs_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

[hw/rtl/fzs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzs_back
// Matching engine: walks the needle over each string, keeps the running
// score and the label result, and registers one result per entry.
// ----------------------------------------------------------------------------
module fzs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fzs_pkg::t_cfg           i_cfg,
    input  fzs_pkg::t_item          i_head,
    input  fzs_pkg::t_qstat         i_qstat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [9:0]              o_entry_index,
    output logic                    o_matched,
    output logic signed [9:0]       o_score
);

    // Per-string state.
    logic [fzs_pkg::NPOS_W-1:0]  r_pos, n_pos;
    logic                        r_hit_seen, n_hit_seen;
    logic [fzs_pkg::GAP_W-1:0]   r_gap, n_gap;
    logic                        r_word_start, n_word_start;
    fzs_pkg::t_score             r_run, n_run;
    // Per-entry state.
    logic [fzs_pkg::LEN_W-1:0]   r_len, n_len;
    logic                        r_lab_match, n_lab_match;
    fzs_pkg::t_score             r_lab_score, n_lab_score;
    logic [fzs_pkg::ENTRY_W-1:0] r_entry, n_entry;
    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [9:0]                  r_out_index, n_out_index;
    logic                        r_out_match, n_out_match;
    fzs_pkg::t_score             r_out_score, n_out_score;

    logic [7:0]                  needle_ch;
    logic                        hit;
    logic                        str_match;
    logic                        res_match;
    fzs_pkg::t_score             add;
    fzs_pkg::t_score             s_add;
    fzs_pkg::t_score             s_gap;
    fzs_pkg::t_score             s_lab;
    fzs_pkg::t_score             bonus;
    fzs_pkg::t_score             res_score;
    logic [fzs_pkg::ENTRY_W-1:0] cur_entry;

    // Take the next transaction when the output register can hold a result.
    assign o_pop = !i_qstat.empty && (!r_out_valid || i_ready);

    assign needle_ch = i_cfg.needle[8*r_pos[fzs_pkg::NIDX_W-1:0] +: 8];
    assign hit       = i_head.has_char && (r_pos < i_cfg.nlen) && (i_head.ch_fold == needle_ch);

    // Hit score: word start, run continuation or plain.
    always_comb begin
        if (r_word_start) begin
            add = fzs_pkg::t_score'(fzs_pkg::ADD_WORD);
        end else if (r_hit_seen && (r_gap == '0)) begin
            add = fzs_pkg::t_score'(fzs_pkg::ADD_RUN);
        end else begin
            add = fzs_pkg::t_score'(fzs_pkg::ADD_OTHER);
        end
        s_add = fzs_pkg::sat_add(r_run, add);
        s_gap = r_hit_seen ? fzs_pkg::sat_add(s_add, -fzs_pkg::t_score'(r_gap)) : s_add;
    end

    // Character step, then end-of-string handling on the updated state.
    always_comb begin
        n_pos        = r_pos;
        n_hit_seen   = r_hit_seen;
        n_gap        = r_gap;
        n_word_start = r_word_start;
        n_run        = r_run;
        n_len        = r_len;
        n_lab_match  = r_lab_match;
        n_lab_score  = r_lab_score;
        n_entry      = r_entry;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_index  = r_out_index;
        n_out_match  = r_out_match;
        n_out_score  = r_out_score;
        str_match    = 1'b0;
        res_match    = 1'b0;
        res_score    = '0;
        s_lab        = '0;
        bonus        = '0;
        cur_entry    = i_head.new_list ? '0 : r_entry;

        if (o_pop) begin
            n_entry = cur_entry;

            if (i_head.has_char) begin
                if (!i_head.in_group && (r_len < fzs_pkg::LEN_W'(fzs_pkg::LEN_CAP))) begin
                    n_len = r_len + 1'b1;
                end
                if (hit) begin
                    n_run      = s_gap;
                    n_hit_seen = 1'b1;
                    n_gap      = '0;
                    n_pos      = r_pos + 1'b1;
                end else if ((r_pos < i_cfg.nlen) && r_hit_seen &&
                             (r_gap < fzs_pkg::GAP_W'(fzs_pkg::GAP_CAP))) begin
                    n_gap = r_gap + 1'b1;
                end
                n_word_start = i_head.sep;
            end

            str_match = (i_cfg.nlen == '0) || (n_pos >= i_cfg.nlen);

            if (i_head.string_end) begin
                if (!i_head.in_group) begin
                    // Label end: keep its outcome for the group string.
                    n_lab_match = str_match;
                    s_lab       = fzs_pkg::sat_add(n_run, fzs_pkg::t_score'(fzs_pkg::LABEL_BONUS));
                    bonus       = fzs_pkg::t_score'(fzs_pkg::LEN_BASE) -
                                  fzs_pkg::t_score'(n_len[fzs_pkg::LEN_W-1:3]);
                    n_lab_score = str_match ? fzs_pkg::sat_add(s_lab, bonus) : '0;
                end else begin
                    // Group end: pick the score and emit one result.
                    if (i_cfg.nlen == '0) begin
                        res_match = 1'b1;
                        res_score = '0;
                    end else begin
                        res_match = r_lab_match || str_match;
                        res_score = r_lab_match ? r_lab_score : n_run;
                        if (!i_head.enabled) begin
                            res_score = fzs_pkg::sat_add(res_score,
                                -fzs_pkg::t_score'(fzs_pkg::DISABLED_PEN));
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_index = 10'(cur_entry);
                    n_out_match = res_match;
                    n_out_score = res_match ? res_score : '0;
                    n_entry     = (cur_entry == fzs_pkg::ENTRY_W'(fzs_pkg::ENTRY_MAX - 1)) ?
                                  '0 : cur_entry + 1'b1;
                    n_len       = '0;
                    n_lab_match = 1'b0;
                    n_lab_score = '0;
                end
                n_pos        = '0;
                n_hit_seen   = 1'b0;
                n_gap        = '0;
                n_word_start = 1'b1;
                n_run        = '0;
            end
        end
    end

    // Control and scoring state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_hit_seen   <= 1'b0;
            r_gap        <= '0;
            r_word_start <= 1'b1;
            r_run        <= '0;
            r_len        <= '0;
            r_lab_match  <= 1'b0;
            r_lab_score  <= '0;
            r_entry      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_hit_seen   <= n_hit_seen;
            r_gap        <= n_gap;
            r_word_start <= n_word_start;
            r_run        <= n_run;
            r_len        <= n_len;
            r_lab_match  <= n_lab_match;
            r_lab_score  <= n_lab_score;
            r_entry      <= n_entry;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_match <= n_out_match;
        r_out_score <= n_out_score;
    end

    assign o_valid       = r_out_valid;
    assign o_entry_index = r_out_index;
    assign o_matched     = r_out_match;
    assign o_score       = r_out_score;

endmodule

[hw/rtl/fuzzy_subsequence_scorer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Streams label and group characters, matches the configured needle as a
// case-folded subsequence and emits one score per entry.
// ----------------------------------------------------------------------------
// Throughput: one character transaction per cycle while the queue has room and the
// result output is not stalled. A result's last character is written into the queue,
// and the matching engine pops it into the output register once that register can
// hold a result.
// The four-entry queue between classifier and matching engine lets either side stall.
// Reset: synchronous, active low; clears the control state at once, no clearing pass.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fzs_pkg::ADDR_W-1:0]  paddr,
    input  logic [fzs_pkg::DATA_W-1:0]  pwdata,
    output logic [fzs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Character input
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_text_char,
    input  logic                        i_has_char,
    input  logic                        i_in_group,
    input  logic                        i_string_end,
    input  logic                        i_entry_enabled,
    input  logic                        i_new_list,
    // Result output
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [9:0]                  o_entry_index,
    output logic                        o_matched,
    output logic signed [9:0]           o_score
);

    logic [5:0]                  r_nlen;
    logic [fzs_pkg::DATA_W-1:0]  r_word [4];
    logic [2:0]                  reg_idx;
    logic                        cfg_wr;
    logic [fzs_pkg::NPOS_W-1:0]  nlen_eff;
    fzs_pkg::t_cfg               cfg;
    fzs_pkg::t_item              push_item;
    fzs_pkg::t_item              head_item;
    fzs_pkg::t_qstat             qstat;
    logic                        push;
    logic                        pop;

    // Register writes.
    assign reg_idx = paddr[fzs_pkg::ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlen <= '0;
            for (int i = 0; i < 4; i++) begin
                r_word[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                fzs_pkg::REG_NLEN:  r_nlen    <= pwdata[5:0];
                fzs_pkg::REG_WORD0: r_word[0] <= pwdata;
                fzs_pkg::REG_WORD1: r_word[1] <= pwdata;
                fzs_pkg::REG_WORD2: r_word[2] <= pwdata;
                fzs_pkg::REG_WORD3: r_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            fzs_pkg::REG_NLEN:  prdata = fzs_pkg::DATA_W'(r_nlen);
            fzs_pkg::REG_WORD0: prdata = r_word[0];
            fzs_pkg::REG_WORD1: prdata = r_word[1];
            fzs_pkg::REG_WORD2: prdata = r_word[2];
            fzs_pkg::REG_WORD3: prdata = r_word[3];
            default:            prdata = '0;
        endcase
    end

    // Needle length limited to the needle storage.
    assign nlen_eff = (r_nlen > 6'(fzs_pkg::NEEDLE_MAX)) ?
                      fzs_pkg::NPOS_W'(fzs_pkg::NEEDLE_MAX) : fzs_pkg::NPOS_W'(r_nlen);

    always_comb begin
        cfg.nlen   = nlen_eff;
        cfg.needle = (8 * fzs_pkg::NEEDLE_MAX)'({r_word[3], r_word[2], r_word[1], r_word[0]});
    end

    fzs_front u_front (
        .i_valid         (i_valid),
        .i_text_char     (i_text_char),
        .i_has_char      (i_has_char),
        .i_in_group      (i_in_group),
        .i_string_end    (i_string_end),
        .i_entry_enabled (i_entry_enabled),
        .i_new_list      (i_new_list),
        .i_qstat         (qstat),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_item          (push_item)
    );

    fzs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (qstat)
    );

    fzs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_head        (head_item),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_index (o_entry_index),
        .o_matched     (o_matched),
        .o_score       (o_score)
    );

    // The queue can never report full and empty together.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty at once");

    // An unmatched entry always carries a zero score.
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_matched) |-> (o_score == '0))
        else $error("unmatched result with nonzero score");

    // Nothing leaves an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");

    // A needle length write takes effect on the next cycle.
    a_nlen_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (reg_idx == fzs_pkg::REG_NLEN)) |=> (r_nlen == $past(pwdata[5:0])))
        else $error("needle length write lost");

endmodule

[test/fzs_score_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzs_score_checker
// Watches the configuration port and both streaming channels of the fuzzy
// subsequence scorer. It keeps its own copy of the needle and of the matching
// state, predicts the score of every entry from the accepted character
// transactions, and compares each result transaction with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module fzs_score_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [fzs_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [fzs_pkg::DATA_W-1:0]  i_pwdata,
    // Character channel
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_text_char,
    input  logic                        i_has_char,
    input  logic                        i_in_group,
    input  logic                        i_string_end,
    input  logic                        i_entry_enabled,
    input  logic                        i_new_list,
    // Result channel
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [9:0]                  i_entry_index,
    input  logic                        i_matched,
    input  logic signed [9:0]           i_score,
    // Status toward the testbench top
    output int                          o_fail_count,
    output int                          o_pending
);
    import fzs_pkg::*;

    typedef struct packed {
        logic [ENTRY_W-1:0] index;
        logic               matched;
        logic [SCORE_W-1:0] score;
    } scored_entry_t;

    scored_entry_t pending_scores[$];
    int            fails;
    int            pend_n;

    // Needle as last written through the configuration port.
    logic [5:0]              cfg_len;
    logic [8*NEEDLE_MAX-1:0] cfg_needle;

    // Matching state of the current string and entry.
    int unsigned hit_pos;
    int unsigned gap_run;
    int unsigned lbl_len;
    int unsigned entry_no;
    bit          hit_any;
    bit          fresh_string;
    bit          lbl_ok;
    logic [7:0]  last_ch;
    int          run_score;
    int          lbl_score;

    assign o_fail_count = fails;
    assign o_pending    = pend_n;

    function automatic int clamp_score(input int v);
        if (v > SCORE_MAX) return SCORE_MAX;
        if (v < SCORE_MIN) return SCORE_MIN;
        return v;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_UNDER || c == CH_DOT || c == CH_DASH
            || c == CH_SLASH;
    endfunction

    task automatic clear_string_state();
        hit_pos      = 0;
        hit_any      = 1'b0;
        gap_run      = 0;
        last_ch      = 8'h00;
        fresh_string = 1'b1;
        run_score    = 0;
    endtask

    // Advance the prediction by one accepted character transaction.
    task automatic score_char(input logic [7:0] c, input bit has, input bit grp,
                              input bit send_end, input bit en, input bit nl);
        int unsigned   eff;
        int            add;
        int            bonus;
        int            s;
        bit            whole;
        scored_entry_t res;
        eff = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : cfg_len;
        if (nl) entry_no = 0;

        if (has) begin
            if (!grp && lbl_len < LEN_CAP) lbl_len++;
            // Past a complete needle, labels only add to their length.
            if (hit_pos < eff) begin
                if (fold_case(c) == cfg_needle[8*hit_pos +: 8]) begin
                    if (fresh_string || is_separator(last_ch)) begin
                        add = ADD_WORD;
                    end else if (hit_any && gap_run == 0) begin
                        add = ADD_RUN;
                    end else begin
                        add = ADD_OTHER;
                    end
                    run_score = clamp_score(run_score + add);
                    if (hit_any) run_score = clamp_score(run_score - int'(gap_run));
                    hit_any = 1'b1;
                    gap_run = 0;
                    hit_pos++;
                end else if (hit_any && gap_run < GAP_CAP) begin
                    gap_run++;
                end
            end
            last_ch      = c;
            fresh_string = 1'b0;
        end

        if (send_end) begin
            whole = (eff == 0) || (hit_pos >= eff);
            if (!grp) begin
                // A later label end replaces an earlier one of the same entry.
                lbl_ok = whole;
                if (whole) begin
                    bonus = LEN_BASE - int'(lbl_len >> 3);
                    if (bonus < 0) bonus = 0;
                    lbl_score = clamp_score(clamp_score(run_score + LABEL_BONUS) + bonus);
                end else begin
                    lbl_score = 0;
                end
            end else begin
                s           = 0;
                res.index   = entry_no[ENTRY_W-1:0];
                res.matched = 1'b1;
                if (eff == 0) begin
                    s = 0;
                end else if (lbl_ok) begin
                    s = lbl_score;
                end else if (whole) begin
                    s = run_score;
                end else begin
                    res.matched = 1'b0;
                end
                if (eff != 0 && res.matched && !en) s = clamp_score(s - DISABLED_PEN);
                res.score = res.matched ? s[SCORE_W-1:0] : '0;
                pending_scores = {pending_scores, res};
                entry_no  = (entry_no + 1 >= ENTRY_MAX) ? 0 : entry_no + 1;
                lbl_len   = 0;
                lbl_ok    = 1'b0;
                lbl_score = 0;
            end
            clear_string_state();
        end
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_result();
        scored_entry_t want;
        if (pending_scores.size() == 0) begin
            $error("unexpected result: entry_index %0d matched %0d score %0d",
                   i_entry_index, i_matched, i_score);
            fails++;
        end else begin
            want = pending_scores.pop_front();
            if (i_entry_index !== want.index) begin
                $error("entry_index mismatch: expected %0d, actual %0d",
                       want.index, i_entry_index);
                fails++;
            end
            if (i_matched !== want.matched) begin
                $error("matched mismatch: expected %0d, actual %0d",
                       want.matched, i_matched);
                fails++;
            end
            if (i_score !== want.score) begin
                $error("score mismatch: expected %0d, actual %0d",
                       $signed(want.score), i_score);
                fails++;
            end
        end
    endtask

    initial begin
        fails  = 0;
        pend_n = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_scores.delete();
            cfg_len    = '0;
            cfg_needle = '0;
            clear_string_state();
            lbl_len    = 0;
            lbl_ok     = 1'b0;
            lbl_score  = 0;
            entry_no   = 0;
        end else begin
            // Register writes; addresses outside the map are ignored.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_NLEN:  cfg_len = i_pwdata[5:0];
                    REG_WORD0: cfg_needle[0   +: 64] = i_pwdata;
                    REG_WORD1: cfg_needle[64  +: 64] = i_pwdata;
                    REG_WORD2: cfg_needle[128 +: 64] = i_pwdata;
                    REG_WORD3: cfg_needle[192 +: 64] = i_pwdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                score_char(i_text_char, i_has_char, i_in_group, i_string_end,
                           i_entry_enabled, i_new_list);
            end
        end
        pend_n = pending_scores.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the fuzzy subsequence scorer. A short directed sequence covers
// word starts, case folding, separators, empty strings, disabled entries,
// groups without labels and repeated labels. Random phases then reprogram the
// needle (empty, single character, full length, over-long, all-ones and random
// bytes) and stream mostly well-formed entries with noise mixed in, while both
// channels stall at random. The checker predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import fzs_pkg::*;

    localparam int         N_PHASES       = 10;
    localparam int         PHASE_ITEMS    = 95;
    localparam int         RX_HOLD_CYCLES = 80;
    localparam int         DRAIN_CYCLES   = 12;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] REG_UNUSED     = 3'd7;

    typedef logic [7:0] text_q_t[$];

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_text_char;
    logic               i_has_char;
    logic               i_in_group;
    logic               i_string_end;
    logic               i_entry_enabled;
    logic               i_new_list;
    logic               o_valid;
    logic               i_ready;
    logic [9:0]         o_entry_index;
    logic               o_matched;
    logic signed [9:0]  o_score;

    int                 chk_fails;
    int                 chk_pending;
    int                 items_sent;
    int                 idle_cycles;
    bit                 noise_on;
    bit                 tx_steady;
    bit                 rx_hold_req;
    bit                 rx_hold_done;
    logic [7:0]         ndl [NEEDLE_MAX];
    int                 ndl_use;

    fuzzy_subsequence_scorer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_text_char     (i_text_char),
        .i_has_char      (i_has_char),
        .i_in_group      (i_in_group),
        .i_string_end    (i_string_end),
        .i_entry_enabled (i_entry_enabled),
        .i_new_list      (i_new_list),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_entry_index   (o_entry_index),
        .o_matched       (o_matched),
        .o_score         (o_score)
    );

    fzs_score_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_text_char     (i_text_char),
        .i_has_char      (i_has_char),
        .i_in_group      (i_in_group),
        .i_string_end    (i_string_end),
        .i_entry_enabled (i_entry_enabled),
        .i_new_list      (i_new_list),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_entry_index   (o_entry_index),
        .i_matched       (o_matched),
        .i_score         (o_score),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending)
    );

    // Clock, 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: random stalls, steady stretches and one long hold-off.
    initial begin
        int steady_left;
        int roll;
        i_ready      = 1'b0;
        rx_hold_done = 1'b0;
        steady_left  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_ready = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_done = 1'b1;
            end else if (steady_left > 0) begin
                i_ready = 1'b1;
                steady_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    i_ready     = 1'b1;
                    steady_left = $urandom_range(20, 60);
                end else if (roll < 75) begin
                    i_ready = 1'b1;
                end else if (roll < 97) begin
                    i_ready = 1'b0;
                    repeat ($urandom_range(0, 2)) @(negedge i_clk);
                end else begin
                    i_ready = 1'b0;
                    repeat ($urandom_range(8, 25)) @(negedge i_clk);
                end
            end
        end
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Fill the needle bytes by content mode and program all needle registers.
    task automatic program_needle(input int len, input int mode);
        logic [63:0] value;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            case (mode)
                1: ndl[i] = 8'hFF;
                2: ndl[i] = 8'($urandom_range(0, 255));
                default: begin
                    case ($urandom_range(0, 9))
                        8:       ndl[i] = 8'("0" + $urandom_range(0, 9));
                        9:       ndl[i] = $urandom_range(0, 1) ? CH_UNDER : CH_DOT;
                        default: ndl[i] = 8'("a" + $urandom_range(0, 25));
                    endcase
                end
            endcase
        end
        // Bits above the length field carry random data.
        value      = {$urandom, $urandom};
        value[5:0] = 6'(len);
        write_reg(REG_NLEN, value);
        for (int w = 0; w < 4; w++) begin
            for (int b = 0; b < 8; b++) value[8*b +: 8] = ndl[8*w + b];
            write_reg(REG_WORD0 + 3'(w), value);
        end
        ndl_use = (len > NEEDLE_MAX) ? NEEDLE_MAX : len;
    endtask

    // Offer one character transaction and wait for its acceptance.
    task automatic send_item(input logic [7:0] c, input bit has, input bit grp,
                             input bit send_end, input bit en, input bit nl);
        int roll;
        if (!tx_steady) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                repeat ($urandom_range(1, 3)) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                end
            end else if (roll < 27) begin
                repeat ($urandom_range(8, 25)) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                end
            end
        end
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_text_char     = c;
        i_has_char      = has;
        i_in_group      = grp;
        i_string_end    = send_end;
        i_entry_enabled = en;
        i_new_list      = nl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic bit roll_new_list();
        return noise_on && ($urandom_range(0, 99) < 2);
    endfunction

    // Send a whole string; mix scrambles the kind bit of all but the last item.
    task automatic send_bytes(input text_q_t s, input bit grp, input bit en, input bit mix);
        bit last;
        if (s.size() == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, grp, 1'b1, en, roll_new_list());
        end else begin
            foreach (s[i]) begin
                last = (i == s.size() - 1);
                if (noise_on && $urandom_range(0, 99) < 4) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              1'b0, 1'($urandom_range(0, 1)), roll_new_list());
                end
                send_item(s[i], 1'b1, (mix && !last) ? 1'($urandom_range(0, 1)) : grp,
                          last, last ? en : 1'($urandom_range(0, 1)), roll_new_list());
            end
        end
    endtask

    task automatic send_text(input string s, input bit grp, input bit en);
        text_q_t q;
        for (int i = 0; i < s.len(); i++) q = {q, s[i]};
        send_bytes(q, grp, en, 1'b0);
    endtask

    // Filler text: separators, letters of both cases, needle bytes, raw bytes.
    function automatic logic [7:0] filler();
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0:       return CH_SPACE;
                    1:       return CH_UNDER;
                    2:       return CH_DOT;
                    3:       return CH_DASH;
                    default: return CH_SLASH;
                endcase
            end
            2, 3, 4, 5: return 8'("a" + $urandom_range(0, 25));
            6, 7:       return 8'("A" + $urandom_range(0, 25));
            8:          return (ndl_use > 0) ? ndl[$urandom_range(0, ndl_use - 1)] : 8'h61;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a string; when aimed, the needle is spread through it, sometimes
    // with one character dropped, and uppercase letters test case folding.
    task automatic gen_text(output text_q_t s, input bit aim);
        int         skip;
        int         roll;
        logic [7:0] c;
        s    = {};
        skip = -1;
        if (aim && ndl_use > 0 && $urandom_range(0, 4) == 0) begin
            skip = $urandom_range(0, ndl_use - 1);
        end
        if (aim) begin
            for (int k = 0; k < ndl_use; k++) begin
                roll = $urandom_range(0, 9);
                if (roll >= 9) begin
                    repeat ($urandom_range(3, 6)) s = {s, filler()};
                end else if (roll >= 5) begin
                    repeat ($urandom_range(1, 2)) s = {s, filler()};
                end
                c = ndl[k];
                if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - CASE_OFS;
                if (k != skip) s = {s, c};
            end
        end else begin
            repeat ($urandom_range(0, 10)) s = {s, filler()};
        end
        // Now and then a long tail pushes the label length past saturation.
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(40, 75)) s = {s, filler()};
    endtask

    // One entry: mostly label then group, sometimes a broken sequence.
    task automatic send_entry();
        text_q_t lbl;
        text_q_t grp_s;
        int      kind;
        bit      en;
        kind = $urandom_range(0, 99);
        en   = 1'($urandom_range(0, 1));
        gen_text(lbl, $urandom_range(0, 2) != 0);
        gen_text(grp_s, $urandom_range(0, 2) == 0);
        if (kind < 85) begin
            send_bytes(lbl, 1'b0, 1'b1, 1'b0);
            send_bytes(grp_s, 1'b1, en, 1'b0);
        end else if (kind < 90) begin
            // Group string with no label before it.
            send_bytes(grp_s, 1'b1, en, 1'b0);
        end else if (kind < 95) begin
            // Two labels; the second one decides.
            send_bytes(lbl, 1'b0, 1'b1, 1'b0);
            gen_text(lbl, 1'($urandom_range(0, 1)));
            send_bytes(lbl, 1'b0, 1'b1, 1'b0);
            send_bytes(grp_s, 1'b1, en, 1'b0);
        end else begin
            // Strings whose items disagree on their kind.
            send_bytes(lbl, 1'b0, 1'b1, 1'b1);
            send_bytes(grp_s, 1'b1, en, 1'b1);
        end
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Main stimulus and verdict.
    initial begin
        int len;
        int mode;
        int target;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_valid         = 1'b0;
        i_text_char     = 8'h00;
        i_has_char      = 1'b0;
        i_in_group      = 1'b0;
        i_string_end    = 1'b0;
        i_entry_enabled = 1'b0;
        i_new_list      = 1'b0;
        items_sent      = 0;
        noise_on        = 1'b0;
        tx_steady       = 1'b0;
        rx_hold_req     = 1'b0;
        ndl_use         = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with needle "ab"; the other needle bytes are all ones.
        program_needle(2, 1);
        ndl[0] = "a";
        ndl[1] = "b";
        write_reg(REG_WORD0, {48'hFFFF_FFFF_FFFF, ndl[1], ndl[0]});
        write_reg(REG_UNUSED, {$urandom, $urandom});

        // Uppercase hits at string start and after an underscore; empty group.
        send_text("A_B", 1'b0, 1'b1);
        send_text("", 1'b1, 1'b1);
        // Restart of the list on an empty item, zero byte, run of hits, disabled.
        send_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        send_text("ab", 1'b0, 1'b1);
        send_text("", 1'b1, 1'b0);
        // Label that fails, group with dot and dash word starts.
        send_item(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        send_text(".a-b", 1'b1, 1'b1);
        // Group without a label, slash and space word starts, disabled.
        send_text("/A b", 1'b1, 1'b0);
        // Second label overrides the first; text goes on after the needle ends.
        send_text("ab", 1'b0, 1'b1);
        send_text("z", 1'b0, 1'b1);
        send_text("abab", 1'b1, 1'b1);

        // Random phases with different needles.
        noise_on = 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       len = 0;
                1:       len = NEEDLE_MAX;
                2:       len = 63;
                3:       len = 1;
                4:       len = $urandom_range(NEEDLE_MAX + 1, 62);
                default: len = $urandom_range(2, 8);
            endcase
            mode = (ph == 5) ? 1 : (ph == 6) ? 2 : 0;
            program_needle(len, mode);
            tx_steady = ($urandom_range(0, 3) == 0);
            // Fill the block while the receiver holds off.
            if (ph == 0) begin
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_entry();
        end

        wait_idle();
        if (chk_fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/fzs_pkg.sv
hw/rtl/fzs_front.sv
hw/rtl/fzs_queue.sv
hw/rtl/fzs_back.sv
hw/rtl/fuzzy_subsequence_scorer.sv
test/fzs_score_checker.sv
test/tb_top.sv
